// ----- rtl/pngc_pkg.sv -----
// ----------------------------------------------------------------------------
// pngc_pkg
// shared types, codes and crc helper for the png chunk stream checker
// ----------------------------------------------------------------------------
package pngc_pkg;

  // input beat: one file byte and an end-of-file flag
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [1:0]  event_kind;
    logic [2:0]  error_code;
    logic [31:0] chunk_type;
    logic [30:0] chunk_length;
    logic [30:0] image_width;
    logic [30:0] image_height;
    logic [7:0]  bit_depth;
    logic [7:0]  color_type;
    logic [7:0]  interlace;
  } out_item_t;

  // event kinds
  localparam logic [1:0] EV_CHUNK = 2'd0;
  localparam logic [1:0] EV_ERROR = 2'd1;
  localparam logic [1:0] EV_DONE  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_SIG      = 3'd1;
  localparam logic [2:0] ERR_NO_IHDR  = 3'd2;
  localparam logic [2:0] ERR_COMPRESS = 3'd3;
  localparam logic [2:0] ERR_FILTER   = 3'd4;
  localparam logic [2:0] ERR_CRC      = 3'd5;
  localparam logic [2:0] ERR_TRUNC    = 3'd6;

  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

  // parser phases, one-hot
  typedef enum logic [5:0] {
    PH_SIG  = 6'b000001,
    PH_LEN  = 6'b000010,
    PH_TYPE = 6'b000100,
    PH_DATA = 6'b001000,
    PH_CRC  = 6'b010000,
    PH_STOP = 6'b100000
  } phase_e;

  // expected signature byte at a given position
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0: val = 8'h89;
      3'd1: val = 8'h50;
      3'd2: val = 8'h4E;
      3'd3: val = 8'h47;
      3'd4: val = 8'h0D;
      3'd5: val = 8'h0A;
      3'd6: val = 8'h1A;
      3'd7: val = 8'h0A;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // reflected crc-32 update by one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  data);
    logic [31:0] c;
    logic [7:0]  b;
    c = crc_in;
    b = data;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ b[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
      b = b >> 1;
    end
    return c;
  endfunction

endpackage

// ----- rtl/pngc_in_reg.sv -----
// ----------------------------------------------------------------------------
// pngc_in_reg
// input register: holds one byte beat until the parser takes it
// ----------------------------------------------------------------------------
module pngc_in_reg import pngc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  input  logic     take_i,
  output logic     valid_o,
  output in_item_t item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- rtl/pngc_parser.sv -----
// ----------------------------------------------------------------------------
// pngc_parser
// per-byte parse state, crc update, ihdr capture and event generation
// ----------------------------------------------------------------------------
module pngc_parser import pngc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_item_t  item_i,
  output logic      res_valid_o,
  output out_item_t res_o
);

  phase_e      phase_q, phase_d;
  logic [30:0] cnt_q, cnt_d;
  logic [31:0] crc_q, crc_d;
  logic [30:0] len_q, len_d;
  logic [31:0] type_q, type_d;
  logic [31:0] scrc_q, scrc_d;
  logic        seen_q, seen_d;
  logic [30:0] hw_q, hw_d;
  logic [30:0] hh_q, hh_d;
  logic [7:0]  depth_q, depth_d;
  logic [7:0]  color_q, color_d;
  logic [7:0]  comp_q, comp_d;
  logic [7:0]  filt_q, filt_d;
  logic [7:0]  ilace_q, ilace_d;

  logic [7:0]  b;
  logic        last;
  logic [30:0] cnt_inc;
  logic        has_res;
  logic [1:0]  kind;
  logic [2:0]  err;
  logic        info;

  assign b       = item_i.data_byte;
  assign last    = item_i.last_byte;
  assign cnt_inc = cnt_q + 31'd1;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    crc_d   = crc_q;
    len_d   = len_q;
    type_d  = type_q;
    scrc_d  = scrc_q;
    seen_d  = seen_q;
    hw_d    = hw_q;
    hh_d    = hh_q;
    depth_d = depth_q;
    color_d = color_q;
    comp_d  = comp_q;
    filt_d  = filt_q;
    ilace_d = ilace_q;
    has_res = 1'b0;
    kind    = EV_CHUNK;
    err     = ERR_NONE;
    info    = 1'b1;

    case (phase_q)
      PH_SIG: begin
        if (b != sig_byte(cnt_q[2:0])) begin
          has_res = 1'b1;
          kind    = EV_ERROR;
          err     = ERR_SIG;
          info    = 1'b0;
          phase_d = PH_STOP;
        end else if (cnt_q[2:0] == 3'd7) begin
          phase_d = PH_LEN;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_LEN: begin
        len_d = {len_q[22:0], b};
        if (cnt_q[1:0] == 2'd3) begin
          phase_d = PH_TYPE;
          cnt_d   = '0;
          crc_d   = CRC_INIT;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_TYPE: begin
        type_d = {type_q[23:0], b};
        crc_d  = crc_byte(crc_q, b);
        if (cnt_q[1:0] == 2'd3) begin
          cnt_d   = '0;
          scrc_d  = '0;
          phase_d = (len_q != '0) ? PH_DATA : PH_CRC;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_DATA: begin
        crc_d = crc_byte(crc_q, b);
        if (!seen_q && type_q == TYPE_IHDR) begin
          if (cnt_q < 31'd4) begin
            hw_d = {hw_q[22:0], b};
          end else if (cnt_q < 31'd8) begin
            hh_d = {hh_q[22:0], b};
          end else if (cnt_q == 31'd8) begin
            depth_d = b;
          end else if (cnt_q == 31'd9) begin
            color_d = b;
          end else if (cnt_q == 31'd10) begin
            comp_d = b;
          end else if (cnt_q == 31'd11) begin
            filt_d = b;
          end else if (cnt_q == 31'd12) begin
            ilace_d = b;
          end
        end
        if (cnt_inc == len_q) begin
          phase_d = PH_CRC;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_CRC: begin
        scrc_d = {scrc_q[23:0], b};
        if (cnt_q[1:0] == 2'd3) begin
          cnt_d = '0;
          // crc first, then ihdr order, then header methods
          if ((crc_q ^ CRC_INIT) != scrc_d) begin
            err = ERR_CRC;
          end else if (!seen_q && type_q != TYPE_IHDR) begin
            err = ERR_NO_IHDR;
          end else if (!seen_q) begin
            seen_d = 1'b1;
            if (comp_q != 8'd0) begin
              err = ERR_COMPRESS;
            end else if (filt_q != 8'd0) begin
              err = ERR_FILTER;
            end
          end
          has_res = 1'b1;
          if (err != ERR_NONE) begin
            kind    = EV_ERROR;
            phase_d = PH_STOP;
          end else if (type_q == TYPE_IEND) begin
            kind    = EV_DONE;
            phase_d = PH_STOP;
          end else begin
            kind    = EV_CHUNK;
            phase_d = PH_LEN;
          end
        end else begin
          cnt_d = cnt_inc;
        end
      end
      default: begin
      end
    endcase

    // end of file before iend or an error
    if (last && phase_q != PH_STOP && (!has_res || kind == EV_CHUNK)) begin
      has_res = 1'b1;
      kind    = EV_ERROR;
      err     = ERR_TRUNC;
      info    = 1'b0;
    end

    res_o.event_kind   = kind;
    res_o.error_code   = err;
    res_o.chunk_type   = info ? type_d : '0;
    res_o.chunk_length = info ? len_d : '0;
    res_o.image_width  = hw_d;
    res_o.image_height = hh_d;
    res_o.bit_depth    = depth_d;
    res_o.color_type   = color_d;
    res_o.interlace    = ilace_d;

    // last byte rearms for the next file
    if (last) begin
      phase_d = PH_SIG;
      cnt_d   = '0;
      crc_d   = CRC_INIT;
      len_d   = '0;
      type_d  = '0;
      scrc_d  = '0;
      seen_d  = 1'b0;
      hw_d    = '0;
      hh_d    = '0;
      depth_d = '0;
      color_d = '0;
      comp_d  = '0;
      filt_d  = '0;
      ilace_d = '0;
    end
  end

  assign res_valid_o = has_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIG;
      cnt_q   <= '0;
      crc_q   <= CRC_INIT;
      len_q   <= '0;
      type_q  <= '0;
      scrc_q  <= '0;
      seen_q  <= 1'b0;
      hw_q    <= '0;
      hh_q    <= '0;
      depth_q <= '0;
      color_q <= '0;
      comp_q  <= '0;
      filt_q  <= '0;
      ilace_q <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      len_q   <= len_d;
      type_q  <= type_d;
      scrc_q  <= scrc_d;
      seen_q  <= seen_d;
      hw_q    <= hw_d;
      hh_q    <= hh_d;
      depth_q <= depth_d;
      color_q <= color_d;
      comp_q  <= comp_d;
      filt_q  <= filt_d;
      ilace_q <= ilace_d;
    end
  end

endmodule

// ----- rtl/pngc_out_reg.sv -----
// ----------------------------------------------------------------------------
// pngc_out_reg
// result register toward the output channel
// ----------------------------------------------------------------------------
module pngc_out_reg import pngc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  out_item_t item_i,
  output logic      ready_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      valid_q, valid_d;
  out_item_t item_q;

  // free when empty or when the held beat leaves this cycle
  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = load_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

// ----- rtl/png_chunk_stream_checker.sv -----
// ----------------------------------------------------------------------------
// png_chunk_stream_checker
// byte-serial png signature, chunk and crc-32 checker
// ----------------------------------------------------------------------------
// The block takes a png file one byte per beat, last_byte marking the final
// byte, and accepts a new byte every cycle while the result register is
// not stalled. A beat is held in an input register, the parser then
// advances its state and running crc-32 by that byte, and any event is
// registered in the result register, from which it leaves when the
// receiver does not stall. The sustained rate of one byte per cycle is set
// by the byte-wide crc update and counter step in the parser; a result held
// by a stalled receiver stops the parser and, from the next beat on, stalls
// the input. Events: chunk completed, error (bad signature, first chunk not
// IHDR, nonzero compression or filter method, crc mismatch, truncated file)
// and IEND done. After an error or IEND the bytes are dropped silently
// until the last byte, which rearms the parser.
// ----------------------------------------------------------------------------
module png_chunk_stream_checker import pngc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  // byte input channel
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  // event output channel
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      ir_valid;
  in_item_t  ir_item;
  logic      out_ready;
  logic      take;
  logic      res_valid;
  out_item_t res_item;

  // byte moves from input register through the parser when the result
  // register can take whatever it may produce
  assign take = ir_valid && out_ready;

  pngc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .take_i     (take),
    .valid_o    (ir_valid),
    .item_o     (ir_item)
  );

  pngc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (take),
    .item_i      (ir_item),
    .res_valid_o (res_valid),
    .res_o       (res_item)
  );

  pngc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take && res_valid),
    .item_i      (res_item),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- rtl/pngc_checker.sv -----
// ----------------------------------------------------------------------------
// pngc_checker
// port-level checks for the png chunk stream checker
// ----------------------------------------------------------------------------
module pngc_checker import pngc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // stalled byte beat holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("stalled byte beat changed");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result beat changed");

  // chunk and done events carry no error, error events carry one
  a_err_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_item_o.event_kind == EV_ERROR) ==
                     (out_item_o.error_code != ERR_NONE)))
    else $error("error code does not match event kind");

  a_kind_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.event_kind == EV_CHUNK ||
                     out_item_o.event_kind == EV_ERROR ||
                     out_item_o.event_kind == EV_DONE))
    else $error("unused event kind");

  // signature and truncation errors carry no chunk info
  a_no_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.error_code == ERR_SIG ||
                    out_item_o.error_code == ERR_TRUNC)
      |-> out_item_o.chunk_type == '0 && out_item_o.chunk_length == '0)
    else $error("chunk info on chunkless error");

endmodule

bind png_chunk_stream_checker pngc_checker u_pngc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
